@@ rtl/core/rfsb_pkg.sv @@
// ----------------------------------------------------------------------------
// rfsb_pkg
// types, codes and preset table shared by the register file blocks
// ----------------------------------------------------------------------------
package rfsb_pkg;

    localparam int ADDR_W   = 8;
    localparam int DATA_W   = 8;
    localparam int SAMPLE_W = 24;
    localparam int ACTION_W = 2;
    localparam int POS_W    = 3;

    // bus actions
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd2;

    // result source select
    localparam int SRC_W = 2;
    localparam logic [SRC_W-1:0] SRC_ZERO  = 2'd0;
    localparam logic [SRC_W-1:0] SRC_MEM   = 2'd1;
    localparam logic [SRC_W-1:0] SRC_BURST = 2'd2;

    localparam logic [ADDR_W-1:0] FIFO_DATA_ADDR = 8'h07;
    localparam logic [POS_W-1:0]  BURST_LEN      = 3'd6;

    // divide by three: floor(x * ceil(2^25 / 3) / 2^25), exact for 24-bit x
    localparam int               DIV3_SHIFT = 25;
    localparam logic [DIV3_SHIFT-1:0] DIV3_RECIP = 25'h0AAAAAB;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic clear;
        logic step;
    } burst_ctrl_t;

    // reset contents of the register file
    function automatic logic [DATA_W-1:0] preset_byte(input logic [ADDR_W-1:0] addr);
        logic [DATA_W-1:0] val;
        case (addr)
            8'h08:   val = 8'h4F;
            8'h09:   val = 8'h03;
            8'h0A:   val = 8'h27;
            8'h0C:   val = 8'h0A;
            8'h0D:   val = 8'h0A;
            8'hFE:   val = 8'h02;
            8'hFF:   val = 8'h15;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/core/register_file_with_sample_burst.sv @@
// ----------------------------------------------------------------------------
// register_file_with_sample_burst
// bus-slave register file with pointer auto-increment and sample burst reads
// ----------------------------------------------------------------------------
// datapath: an accepted input word is held in the input register, then in the result register
// throughput: one word per cycle; a stalled output holds the input register
// the store read port is registered and the red divide is one 24x25 multiply
// reset: synchronous active-low aresetn clears pointer, load flag, burst
// position, written-entry flags and both handshake stages; the store reads
// its id and configuration presets right after reset, no clearing pass
// ----------------------------------------------------------------------------
module register_file_with_sample_burst (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // write_byte[7:0], ir_value[31:8]
    input  logic [rfsb_pkg::ACTION_W-1:0] s_tuser,  // action[1:0]
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata   // read_byte[7:0]
);
    import rfsb_pkg::*;

    // input register
    logic                st1_valid_reg;
    logic [ACTION_W-1:0] st1_action_reg;
    logic [DATA_W-1:0]   st1_wbyte_reg;
    logic [SAMPLE_W-1:0] st1_ir_reg;

    // slave state
    logic [ADDR_W-1:0]   ptr_reg;
    logic [ADDR_W-1:0]   ptr_next;
    logic                loaded_reg;
    logic                loaded_next;

    // result register
    logic                m_valid_reg;
    logic [SRC_W-1:0]    src_reg;
    logic [SRC_W-1:0]    src_next;
    logic [DATA_W-1:0]   burst_byte_reg;

    logic                advance;
    logic                fifo_hit;
    logic                is_write;
    logic                is_read;
    logic                is_stop;
    mem_req_t            mem_req;
    burst_ctrl_t         burst_ctrl;
    logic [DATA_W-1:0]   mem_rd_data;
    logic [DATA_W-1:0]   burst_byte;
    logic [POS_W-1:0]    burst_pos;

    // the stage moves when the result slot is empty or being drained
    assign advance  = st1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !st1_valid_reg || advance;

    assign is_write = advance && (st1_action_reg == ACT_WRITE);
    assign is_read  = advance && (st1_action_reg == ACT_READ);
    assign is_stop  = advance && (st1_action_reg == ACT_STOP);
    assign fifo_hit = (ptr_reg == FIFO_DATA_ADDR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            st1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            st1_action_reg <= s_tuser;
            st1_wbyte_reg  <= s_tdata[7:0];
            st1_ir_reg     <= s_tdata[31:8];
        end
    end

    // first write of a transaction loads the pointer, later writes store
    // and step it; stop only drops the load flag
    always_comb begin
        ptr_next    = ptr_reg;
        loaded_next = loaded_reg;
        if (is_write) begin
            if (!loaded_reg) begin
                ptr_next    = st1_wbyte_reg;
                loaded_next = 1'b1;
            end else begin
                ptr_next = ptr_reg + ADDR_W'(1);
            end
        end else if (is_stop) begin
            loaded_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg    <= '0;
            loaded_reg <= 1'b0;
        end else begin
            ptr_reg    <= ptr_next;
            loaded_reg <= loaded_next;
        end
    end

    // store access: a write never coincides with a read
    always_comb begin
        mem_req.we    = is_write && loaded_reg;
        mem_req.re    = is_read && !fifo_hit;
        mem_req.addr  = ptr_reg;
        mem_req.wdata = st1_wbyte_reg;
    end

    always_comb begin
        burst_ctrl.clear = is_write && !loaded_reg;
        burst_ctrl.step  = is_read && fifo_hit;
    end

    rfsb_regmem u_regmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    rfsb_burst u_burst (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (burst_ctrl),
        .ir_value   (st1_ir_reg),
        .burst_byte (burst_byte),
        .pos        (burst_pos)
    );

    // pick where the result byte comes from
    always_comb begin
        if (st1_action_reg == ACT_READ) begin
            src_next = fifo_hit ? SRC_BURST : SRC_MEM;
        end else begin
            src_next = SRC_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            src_reg     <= SRC_ZERO;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
            src_reg     <= src_next;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            burst_byte_reg <= burst_byte;
        end
    end

    always_comb begin
        case (src_reg)
            SRC_MEM:   m_tdata = mem_rd_data;
            SRC_BURST: m_tdata = burst_byte_reg;
            default:   m_tdata = '0;
        endcase
    end

    assign m_tvalid = m_valid_reg;

    // ---------------------------------------------------------------- checks

    // an empty result slot never blocks the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with empty result slot");

    // reads and stops leave the register pointer alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (is_read || is_stop) |=> $stable(ptr_reg))
        else $error("pointer moved on a read or stop");

    // a pointer load takes the written byte and restarts the burst
    assert property (@(posedge aclk) disable iff (!aresetn)
        (is_write && !loaded_reg) |=>
            (loaded_reg && ptr_reg == $past(st1_wbyte_reg) && burst_pos == '0))
        else $error("pointer load did not take effect");

    // after a fifo read the burst position never runs past the burst length
    assert property (@(posedge aclk) disable iff (!aresetn)
        burst_pos <= BURST_LEN || !$past(burst_ctrl.step))
        else $error("burst position out of range after a fifo read");

endmodule

@@ rtl/core/rfsb_regmem.sv @@
// ----------------------------------------------------------------------------
// rfsb_regmem
// 256-byte register store, one write or one registered read per cycle
// ----------------------------------------------------------------------------
module rfsb_regmem (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rfsb_pkg::mem_req_t          req,
    output logic [rfsb_pkg::DATA_W-1:0] rd_data
);
    import rfsb_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DATA_W-1:0] rd_mem_reg;
    logic [DATA_W-1:0] rd_preset_reg;
    logic              rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem_reg[req.addr] <= req.wdata;
        end
    end

    // written entries override the preset table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.we) begin
            valid_reg[req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.re) begin
            rd_mem_reg    <= mem_reg[req.addr];
            rd_hit_reg    <= valid_reg[req.addr];
            rd_preset_reg <= preset_byte(req.addr);
        end
    end

    assign rd_data = rd_hit_reg ? rd_mem_reg : rd_preset_reg;

endmodule

@@ rtl/core/rfsb_burst.sv @@
// ----------------------------------------------------------------------------
// rfsb_burst
// six-byte sample burst: red (sample / 3) then ir, big-endian
// ----------------------------------------------------------------------------
module rfsb_burst (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rfsb_pkg::burst_ctrl_t         ctrl,
    input  logic [rfsb_pkg::SAMPLE_W-1:0] ir_value,
    output logic [rfsb_pkg::DATA_W-1:0]   burst_byte,
    output logic [rfsb_pkg::POS_W-1:0]    pos
);
    import rfsb_pkg::*;

    localparam int PROD_W = SAMPLE_W + DIV3_SHIFT;

    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_eff;
    logic [POS_W-1:0]    pos_next;
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] red_value;

    // wrap back to the first byte once the burst is used up
    assign pos_eff = (pos_reg >= BURST_LEN) ? '0 : pos_reg;

    assign prod      = PROD_W'(ir_value) * PROD_W'(DIV3_RECIP);
    assign red_value = prod[PROD_W-1:DIV3_SHIFT];

    always_comb begin
        case (pos_eff)
            3'd0:    burst_byte = red_value[23:16];
            3'd1:    burst_byte = red_value[15:8];
            3'd2:    burst_byte = red_value[7:0];
            3'd3:    burst_byte = ir_value[23:16];
            3'd4:    burst_byte = ir_value[15:8];
            3'd5:    burst_byte = ir_value[7:0];
            default: burst_byte = '0;
        endcase
    end

    always_comb begin
        pos_next = pos_reg;
        if (ctrl.clear) begin
            pos_next = '0;
        end else if (ctrl.step) begin
            pos_next = pos_eff + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule
